[sv/edfs_pkg.sv]
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared types, codes and helpers for the controller and the datapath.
// ----------------------------------------------------------------------------
package edfs_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Result status codes.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_IGNORED = 2'd2;

    // Run state of a task slot.
    typedef enum logic [1:0] {
        RUN_PENDING  = 2'd0,
        RUN_RUNNING  = 2'd1,
        RUN_FINISHED = 2'd2
    } t_run;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_FIND, S_PROC, S_DIV,
        S_CATCH, S_CHECK, S_FINAL, S_RESP
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_ADD, OP_FINISH, OP_IGNORE, OP_TICK, OP_SCAN,
        OP_FIND, OP_FREE, OP_DIV_START, OP_DIV_STEP, OP_CATCH, OP_SEEN,
        OP_CHECK, OP_FINAL
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       enable;
        logic       run_idle;
        logic       idx_last;
        logic       best_vld;
        logic       best_fin;
        logic       best_periodic;
        logic       div_last;
        logic       catch_due;
    } t_stat;

    // A time stamp x is due at t when t - x, taken modulo 2^32, is below 2^31.
    function automatic logic f_due(input logic [31:0] t, input logic [31:0] x);
        logic [31:0] diff;
        diff = t - x;
        return !diff[31];
    endfunction

endpackage

[sv/edfs_ctrl.sv]
// ----------------------------------------------------------------------------
// EDF scheduler controller
// Sequences add, finish and tick requests over the datapath.
// ----------------------------------------------------------------------------
module edfs_ctrl
    import edfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output logic  o_done,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath operation.
    always_comb begin
        n_state   = r_state;
        o_ctrl.op = OP_NONE;
        busy      = (r_state != S_IDLE);
        o_done    = (r_state == S_RESP);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.op = OP_LATCH;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.cmd == CMD_ADD) begin
                    o_ctrl.op = OP_ADD;
                    n_state   = S_RESP;
                end else if (i_stat.cmd == CMD_TICK && i_stat.enable) begin
                    o_ctrl.op = OP_TICK;
                    n_state   = S_SCAN;
                end else if (i_stat.cmd == CMD_FINISH && i_stat.enable
                             && !i_stat.run_idle) begin
                    o_ctrl.op = OP_FINISH;
                    n_state   = S_RESP;
                end else begin
                    o_ctrl.op = OP_IGNORE;
                    n_state   = S_RESP;
                end
            end
            S_SCAN: begin
                o_ctrl.op = OP_SCAN;
                if (i_stat.idx_last) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_ctrl.op = OP_FIND;
                if (i_stat.idx_last) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (!i_stat.best_vld) begin
                    n_state = S_FINAL;
                end else if (i_stat.best_fin) begin
                    if (!i_stat.best_periodic) begin
                        o_ctrl.op = OP_FREE;
                        n_state   = S_FIND;
                    end else begin
                        o_ctrl.op = OP_DIV_START;
                        n_state   = S_DIV;
                    end
                end else begin
                    o_ctrl.op = OP_SEEN;
                    n_state   = S_CHECK;
                end
            end
            S_DIV: begin
                o_ctrl.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_CATCH;
                end
            end
            S_CATCH: begin
                o_ctrl.op = OP_CATCH;
                n_state   = i_stat.catch_due ? S_CHECK : S_FIND;
            end
            S_CHECK: begin
                o_ctrl.op = OP_CHECK;
                n_state   = S_FINAL;
            end
            S_FINAL: begin
                o_ctrl.op = OP_FINAL;
                n_state   = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/edfs_dp.sv]
// ----------------------------------------------------------------------------
// EDF scheduler datapath
// Task slot table, tick and miss counters, deadline search and catch-up unit.
// ----------------------------------------------------------------------------
module edfs_dp
    import edfs_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_period,
    input  logic        i_periodic,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    output logic [1:0]  o_status,
    output logic [2:0]  o_task_id,
    output logic        o_idle,
    output logic        o_fresh_start,
    output logic [31:0] o_missed_total,
    output logic [31:0] o_tick_now
);

    localparam int IW = $clog2(TASKS);

    // Control state, cleared by reset.
    logic             r_enable;
    logic [31:0]      r_tick;
    logic [31:0]      r_missed;
    logic [IW-1:0]    r_run_slot;
    logic             r_run_idle;
    logic [TASKS-1:0] r_used;
    logic [TASKS-1:0] r_new;
    logic [TASKS-1:0] r_inrel;
    logic [TASKS-1:0] r_seen;
    logic [IW-1:0]    r_idx;
    logic             r_best_vld;
    logic             r_pick_vld;

    // Slot payload, written on add or on the first tick scan before any read.
    logic [31:0] r_per [TASKS];
    logic [31:0] r_dl  [TASKS];
    logic [31:0] r_rel [TASKS];
    t_run        r_run [TASKS];
    logic [TASKS-1:0] r_periodic;
    logic [TASKS-1:0] r_miss;

    // Request and working registers.
    logic [1:0]    r_cmd;
    logic [31:0]   r_period_in;
    logic          r_periodic_in;
    logic [IW-1:0] r_best;
    logic [31:0]   r_best_dl;
    logic [31:0]   r_d1;
    logic          r_early;
    logic [31:0]   r_num;
    logic [31:0]   r_rem;
    logic [4:0]    r_dcnt;
    logic [1:0]    r_status;
    logic [2:0]    r_task_id;
    logic          r_fresh;

    logic          idx_last;
    logic [IW-1:0] free_idx;
    logic          free_vld;
    logic [IW+2:0] free_ext;
    logic [IW+2:0] run_ext;
    logic [IW+2:0] best_ext;
    logic          cand;
    logic [31:0]   c_p;
    logic [31:0]   c_dl;
    logic [31:0]   c_rel;
    logic [32:0]   d_tmp;
    logic [32:0]   d_nxt;
    logic [31:0]   d1_calc;

    assign idx_last = (r_idx == IW'(TASKS - 1));

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        free_vld = 1'b0;
        for (int i = TASKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IW'(i);
                free_vld = 1'b1;
            end
        end
    end

    assign free_ext = {3'b000, free_idx};
    assign run_ext  = {3'b000, r_run_slot};
    assign best_ext = {3'b000, r_best};

    // Deadline-set member at the scan index not yet visited in this walk.
    assign cand = r_used[r_idx] && !r_new[r_idx] && !r_inrel[r_idx] && !r_seen[r_idx];

    // Catch-up: deadline + period, or if due, tick + period - (gap mod period).
    assign c_p     = r_per[r_best];
    assign c_dl    = r_early ? r_d1 : (r_tick - r_rem + c_p);
    assign c_rel   = c_dl - c_p;
    assign d1_calc = r_dl[r_best] + c_p;

    // One restoring remainder step.
    always_comb begin
        d_tmp = {r_rem, r_num[31]};
        if (d_tmp >= {1'b0, c_p}) begin
            d_nxt = d_tmp - {1'b0, c_p};
        end else begin
            d_nxt = d_tmp;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.cmd           = r_cmd;
        o_stat.enable        = r_enable;
        o_stat.run_idle      = r_run_idle;
        o_stat.idx_last      = idx_last;
        o_stat.best_vld      = r_best_vld;
        o_stat.best_fin      = (r_run[r_best] == RUN_FINISHED);
        o_stat.best_periodic = r_periodic[r_best];
        o_stat.div_last      = (r_dcnt == 5'd31);
        o_stat.catch_due     = f_due(r_tick, c_rel);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_tick     <= '0;
            r_missed   <= '0;
            r_run_slot <= '0;
            r_run_idle <= 1'b1;
            r_used     <= '0;
            r_new      <= '0;
            r_inrel    <= '0;
            r_seen     <= '0;
            r_idx      <= '0;
            r_best_vld <= 1'b0;
            r_pick_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            case (i_ctrl.op)
                OP_ADD: begin
                    if (free_vld) begin
                        r_used[free_idx]  <= 1'b1;
                        r_new[free_idx]   <= 1'b1;
                        r_inrel[free_idx] <= 1'b0;
                    end
                end
                OP_TICK: begin
                    r_tick     <= r_tick + 32'd1;
                    r_idx      <= '0;
                    r_seen     <= '0;
                    r_best_vld <= 1'b0;
                    r_pick_vld <= 1'b0;
                end
                OP_SCAN: begin
                    if (r_used[r_idx] && r_new[r_idx]) begin
                        r_new[r_idx] <= 1'b0;
                    end else if (r_used[r_idx] && r_inrel[r_idx]
                                 && f_due(r_tick, r_rel[r_idx])) begin
                        r_inrel[r_idx] <= 1'b0;
                    end
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                OP_FIND: begin
                    if (cand && (!r_best_vld || r_dl[r_idx] < r_best_dl)) begin
                        r_best_vld <= 1'b1;
                    end
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                OP_FREE: begin
                    r_seen[r_best] <= 1'b1;
                    r_used[r_best] <= 1'b0;
                    r_best_vld     <= 1'b0;
                end
                OP_DIV_START, OP_SEEN: begin
                    r_seen[r_best] <= 1'b1;
                end
                OP_CATCH: begin
                    if (!f_due(r_tick, c_rel)) begin
                        r_inrel[r_best] <= 1'b1;
                    end
                    r_best_vld <= 1'b0;
                end
                OP_CHECK: begin
                    if (f_due(r_tick, r_dl[r_best]) && !r_miss[r_best]) begin
                        r_missed <= r_missed + 32'd1;
                    end
                    r_pick_vld <= 1'b1;
                end
                OP_FINAL: begin
                    r_run_idle <= !r_pick_vld;
                    r_run_slot <= r_pick_vld ? r_best : '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LATCH: begin
                r_cmd         <= i_cmd;
                r_period_in   <= i_period;
                r_periodic_in <= i_periodic;
                r_fresh       <= 1'b0;
            end
            OP_ADD: begin
                if (free_vld) begin
                    r_periodic[free_idx] <= r_periodic_in;
                    r_per[free_idx]      <= (r_period_in == '0) ? 32'd1 : r_period_in;
                    r_miss[free_idx]     <= 1'b0;
                    r_run[free_idx]      <= RUN_PENDING;
                    r_status             <= STS_OK;
                    r_task_id            <= free_ext[2:0];
                end else begin
                    r_status  <= STS_FULL;
                    r_task_id <= '0;
                end
            end
            OP_FINISH: begin
                r_run[r_run_slot] <= RUN_FINISHED;
                r_status          <= STS_OK;
                r_task_id         <= run_ext[2:0];
            end
            OP_IGNORE: begin
                r_status  <= STS_IGNORED;
                r_task_id <= r_run_idle ? 3'd0 : run_ext[2:0];
            end
            OP_SCAN: begin
                if (r_used[r_idx] && r_new[r_idx]) begin
                    r_rel[r_idx]  <= r_tick;
                    r_dl[r_idx]   <= r_tick + r_per[r_idx];
                    r_miss[r_idx] <= 1'b0;
                    r_run[r_idx]  <= RUN_PENDING;
                end else if (r_used[r_idx] && r_inrel[r_idx]
                             && f_due(r_tick, r_rel[r_idx])) begin
                    r_miss[r_idx] <= 1'b0;
                    r_run[r_idx]  <= RUN_PENDING;
                end
            end
            OP_FIND: begin
                if (cand && (!r_best_vld || r_dl[r_idx] < r_best_dl)) begin
                    r_best    <= r_idx;
                    r_best_dl <= r_dl[r_idx];
                end
            end
            OP_DIV_START: begin
                r_d1    <= d1_calc;
                r_early <= !f_due(r_tick, d1_calc);
                r_num   <= r_tick - d1_calc;
                r_rem   <= '0;
                r_dcnt  <= '0;
            end
            OP_DIV_STEP: begin
                r_rem  <= d_nxt[31:0];
                r_num  <= {r_num[30:0], 1'b0};
                r_dcnt <= r_dcnt + 5'd1;
            end
            OP_CATCH: begin
                r_dl[r_best]  <= c_dl;
                r_rel[r_best] <= c_rel;
                if (f_due(r_tick, c_rel)) begin
                    r_miss[r_best] <= 1'b0;
                    r_run[r_best]  <= RUN_PENDING;
                end
            end
            OP_CHECK: begin
                if (f_due(r_tick, r_dl[r_best]) && !r_miss[r_best]) begin
                    r_miss[r_best] <= 1'b1;
                end
            end
            OP_FINAL: begin
                r_status <= STS_OK;
                if (r_pick_vld) begin
                    r_task_id <= best_ext[2:0];
                    if (r_run[r_best] == RUN_PENDING) begin
                        r_fresh       <= 1'b1;
                        r_run[r_best] <= RUN_RUNNING;
                    end
                end else begin
                    r_task_id <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status       = r_status;
    assign o_task_id      = r_task_id;
    assign o_idle         = r_run_idle;
    assign o_fresh_start  = r_fresh;
    assign o_missed_total = r_missed;
    assign o_tick_now     = r_tick;

    // An idle scheduler always holds running slot zero.
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_idle |-> (r_run_slot == '0))
        else $error("idle with nonzero running slot");

    // The miss count moves by at most one per cycle.
    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_missed != $past(r_missed))
        |-> (r_missed == $past(r_missed) + 32'd1))
        else $error("miss count jumped");

    // The remainder is below the period when catch-up uses it.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_CATCH && !r_early) |-> (r_rem < c_p))
        else $error("catch-up remainder out of range");

endmodule

[sv/edf_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// EDF task scheduler, top level
// Earliest-deadline-first scheduler over a table of task slots.
//
// Channel   Direction  Handshake              Payload
// request   in         start, busy            i_cmd, i_period, i_periodic
// result    out        o_done (strobe)        o_status, o_task_id, o_idle,
//                                             o_fresh_start, o_missed_total,
//                                             o_tick_now
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (enable)
//
// Add, finish and ignored requests go from decode straight to the result.
// A tick scans the slot table once to release tasks, then walks it in deadline
// order until a task is picked or none is left; finished one-shot tasks are
// freed and each finished periodic task is caught up by a 32-step remainder
// unit, one bit per cycle, before its new deadline is written.
// Reset is synchronous and clears the slot table valid bits and counters.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module edf_task_scheduler_top
    import edfs_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_period,
    input  logic        i_periodic,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_task_id,
    output logic        o_idle,
    output logic        o_fresh_start,
    output logic [31:0] o_missed_total,
    output logic [31:0] o_tick_now,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    t_ctrl ctrl;
    t_stat stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    edfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    edfs_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_period       (i_period),
        .i_periodic     (i_periodic),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_task_id      (o_task_id),
        .o_idle         (o_idle),
        .o_fresh_start  (o_fresh_start),
        .o_missed_total (o_missed_total),
        .o_tick_now     (o_tick_now)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF task scheduler regression bench
// Drives add, tick and finish requests with random gaps, predicts every
// result with a cycle-free model of the slot table and checks each strobe.
// ----------------------------------------------------------------------------
module tb_top
    import edfs_pkg::*;
();

    localparam int NSLOT = 8;
    localparam int EXP_DEPTH = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [31:0] i_period;
    logic        i_periodic;
    logic        o_done;
    logic [1:0]  o_status;
    logic [2:0]  o_task_id;
    logic        o_idle;
    logic        o_fresh_start;
    logic [31:0] o_missed_total;
    logic [31:0] o_tick_now;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    edf_task_scheduler_top #(.TASKS(NSLOT)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_period(i_period), .i_periodic(i_periodic),
        .o_done(o_done), .o_status(o_status), .o_task_id(o_task_id),
        .o_idle(o_idle), .o_fresh_start(o_fresh_start),
        .o_missed_total(o_missed_total), .o_tick_now(o_tick_now),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  task_id;
        logic        idle;
        logic        fresh;
        logic [31:0] missed;
        logic [31:0] tick;
    } t_outcome;

    // Scheduler image kept by the bench.
    logic        sch_enable;
    logic [31:0] sch_tick;
    logic [31:0] sch_missed;
    logic [2:0]  sch_run_slot;
    logic        sch_run_idle;
    logic        tab_used [NSLOT];
    logic        tab_new [NSLOT];
    logic        tab_parked [NSLOT];
    logic        tab_periodic [NSLOT];
    logic [31:0] tab_period [NSLOT];
    logic [31:0] tab_deadline [NSLOT];
    logic [31:0] tab_release [NSLOT];
    t_run        tab_run [NSLOT];
    logic        tab_marked [NSLOT];

    // Expected results, in request order.
    t_outcome exp_fifo [EXP_DEPTH];
    int       exp_wr;
    int       exp_rd;
    int       error_count;
    int       seen_done;

    function automatic logic due_at(logic [31:0] t, logic [31:0] x);
        logic [31:0] diff;
        diff = t - x;
        return !diff[31];
    endfunction

    // Next deadline of a finished periodic task, skipping missed periods.
    function automatic logic [31:0] next_deadline(logic [31:0] d, logic [31:0] p,
                                                  logic [31:0] t);
        logic [31:0] d1;
        logic [63:0] k;
        d1 = d + p;
        if (!due_at(t, d1)) return d1;
        k = 64'(t - d1) / 64'(p) + 64'd1;
        return d1 + 32'(k * 64'(p));
    endfunction

    task automatic schedule_tick(output logic fresh);
        logic seen [NSLOT];
        int   pick;
        int   best;
        pick = -1;
        sch_tick = sch_tick + 1;
        for (int s = 0; s < NSLOT; s++) begin
            seen[s] = 1'b0;
            if (tab_used[s] && tab_new[s]) begin
                tab_new[s] = 1'b0;
                tab_release[s] = sch_tick;
                tab_deadline[s] = sch_tick + tab_period[s];
                tab_marked[s] = 1'b0;
                tab_run[s] = RUN_PENDING;
            end
        end
        for (int s = 0; s < NSLOT; s++) begin
            if (tab_used[s] && tab_parked[s] && due_at(sch_tick, tab_release[s])) begin
                tab_parked[s] = 1'b0;
                tab_marked[s] = 1'b0;
                tab_run[s] = RUN_PENDING;
            end
        end
        for (int pass = 0; pass < NSLOT && pick < 0; pass++) begin
            best = -1;
            for (int s = 0; s < NSLOT; s++) begin
                if (!seen[s] && tab_used[s] && !tab_new[s] && !tab_parked[s])
                    if (best < 0 || tab_deadline[s] < tab_deadline[best]) best = s;
            end
            if (best < 0) break;
            seen[best] = 1'b1;
            if (tab_run[best] == RUN_FINISHED) begin
                if (!tab_periodic[best]) begin
                    tab_used[best] = 1'b0;
                    continue;
                end
                tab_deadline[best] = next_deadline(tab_deadline[best], tab_period[best],
                                                   sch_tick);
                tab_release[best] = tab_deadline[best] - tab_period[best];
                if (due_at(sch_tick, tab_release[best])) begin
                    tab_marked[best] = 1'b0;
                    tab_run[best] = RUN_PENDING;
                end else begin
                    tab_parked[best] = 1'b1;
                    continue;
                end
            end
            if (due_at(sch_tick, tab_deadline[best]) && !tab_marked[best]) begin
                tab_marked[best] = 1'b1;
                sch_missed = sch_missed + 1;
            end
            pick = best;
        end
        fresh = 1'b0;
        if (pick < 0) begin
            sch_run_idle = 1'b1;
            sch_run_slot = '0;
        end else begin
            sch_run_idle = 1'b0;
            sch_run_slot = 3'(pick);
            if (tab_run[pick] == RUN_PENDING) begin
                fresh = 1'b1;
                tab_run[pick] = RUN_RUNNING;
            end
        end
    endtask

    // Applies one request to the image and returns the expected result.
    task automatic predict_request(input logic [1:0] cmd, input logic [31:0] period,
                                   input logic periodic, output t_outcome res);
        int   slot;
        logic fresh;
        slot = -1;
        fresh = 1'b0;
        res.status = STS_IGNORED;
        if (cmd == CMD_ADD) begin
            for (int s = 0; s < NSLOT && slot < 0; s++)
                if (!tab_used[s]) slot = s;
            if (slot < 0) begin
                res.status = STS_FULL;
            end else begin
                res.status = STS_OK;
                tab_used[slot] = 1'b1;
                tab_new[slot] = 1'b1;
                tab_parked[slot] = 1'b0;
                tab_periodic[slot] = periodic;
                tab_period[slot] = (period == 0) ? 32'd1 : period;
                tab_marked[slot] = 1'b0;
                tab_run[slot] = RUN_PENDING;
            end
        end else if (cmd == CMD_TICK && sch_enable) begin
            schedule_tick(fresh);
            res.status = STS_OK;
        end else if (cmd == CMD_FINISH && sch_enable && !sch_run_idle) begin
            tab_run[sch_run_slot] = RUN_FINISHED;
            res.status = STS_OK;
        end
        if (cmd == CMD_ADD) res.task_id = (slot < 0) ? 3'd0 : 3'(slot);
        else res.task_id = sch_run_idle ? 3'd0 : sch_run_slot;
        res.idle = sch_run_idle;
        res.fresh = fresh;
        res.missed = sch_missed;
        res.tick = sch_tick;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Clock and timeout.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("edf_task_scheduler_top regression: fail");
        $finish;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            seen_done++;
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_task_id !== want.task_id)
                    report_mismatch("task_id", 32'(o_task_id), 32'(want.task_id));
                if (o_idle !== want.idle)
                    report_mismatch("idle", 32'(o_idle), 32'(want.idle));
                if (o_fresh_start !== want.fresh)
                    report_mismatch("fresh_start", 32'(o_fresh_start), 32'(want.fresh));
                if (o_missed_total !== want.missed)
                    report_mismatch("missed_total", o_missed_total, want.missed);
                if (o_tick_now !== want.tick)
                    report_mismatch("tick_now", o_tick_now, want.tick);
            end
        end
    end

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 95) n = $urandom_range(1, 4);
        else n = $urandom_range(10, 80);
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one request and records its expected result.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] period,
                                input logic periodic);
        t_outcome res;
        random_gap();
        start <= 1'b1;
        i_cmd <= cmd;
        i_period <= period;
        i_periodic <= periodic;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(cmd, period, periodic, res);
        exp_fifo[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
        start <= 1'b0;
        i_cmd <= 2'($urandom);
        i_period <= $urandom;
        i_periodic <= 1'($urandom);
        // The block stays busy after acceptance until its result is given.
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Enable is written only with the block idle.
    task automatic write_enable(input logic value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sch_enable = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_disabled();
        send_request(CMD_TICK, 32'd0, 1'b0);
        send_request(CMD_FINISH, 32'd0, 1'b0);
        send_request(CMD_ADD, 32'd0, 1'b1);
        send_request(2'd3, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_directed();
        send_request(CMD_FINISH, 32'd5, 1'b0);
        send_request(CMD_TICK, 32'd0, 1'b0);
        send_request(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
        send_request(CMD_ADD, 32'h8000_0000, 1'b1);
        for (int i = 0; i < 6; i++) send_request(CMD_ADD, 32'(i + 1), 1'(i));
        send_request(CMD_ADD, 32'd3, 1'b1);
        for (int i = 0; i < 6; i++) begin
            send_request(CMD_TICK, 32'hAAAA_AAAA, 1'b1);
            send_request(CMD_FINISH, 32'h5555_5555, 1'b0);
        end
        send_request(2'd3, 32'd0, 1'b0);
    endtask

    // Mostly add/tick/finish mixes with short periods so tasks cycle through
    // release, deadline miss, catch-up and free.
    task automatic test_random(input int count);
        int          r;
        logic [31:0] p;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) p = $urandom;
            else p = $urandom_range(0, 12);
            if (r < 25) send_request(CMD_ADD, p, $urandom_range(0, 3) != 0);
            else if (r < 65) send_request(CMD_TICK, $urandom, 1'($urandom));
            else if (r < 97) send_request(CMD_FINISH, $urandom, 1'($urandom));
            else send_request(2'd3, $urandom, 1'($urandom));
            if (i == count / 2) drain_results();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_TICK;
        i_period = '0;
        i_periodic = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        error_count = 0;
        seen_done = 0;
        exp_wr = 0;
        exp_rd = 0;
        sch_enable = 1'b0;
        sch_tick = '0;
        sch_missed = '0;
        sch_run_slot = '0;
        sch_run_idle = 1'b1;
        for (int s = 0; s < NSLOT; s++) begin
            tab_used[s] = 1'b0;
            tab_new[s] = 1'b0;
            tab_parked[s] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled();
        write_enable(1'b1);
        test_directed();
        test_random(900);
        write_enable(1'b0);
        test_random(60);
        write_enable(1'b1);
        test_random(950);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) $display("edf_task_scheduler_top regression: pass");
        else $display("edf_task_scheduler_top regression: fail");
        $finish;
    end
endmodule

[edf_task_scheduler_top.f]
sv/edfs_pkg.sv
sv/edfs_ctrl.sv
sv/edfs_dp.sv
sv/edf_task_scheduler_top.sv
tb/tb_top.sv
